/* rtl/iirdf1_pkg.sv */
// Shared types and constants for the direct form I IIR filter.
// No dependencies; imported by every module of the filter.
`default_nettype none

package iirdf1_pkg;

  // Word widths (Q16.16 samples, Q2.30 coefficients).
  localparam int DataW     = 32;
  localparam int CoeffW    = 32;
  localparam int ProdW     = DataW + CoeffW;   // Q18.46 product
  localparam int TermW     = ProdW + 1;        // forward minus feedback product
  localparam int AccW      = ProdW + 3;        // seven products plus rounding
  localparam int FracShift = 30;               // Q x.46 down to Q x.16
  localparam int RoundW    = AccW - FracShift; // rounded sum before saturation

  // History depth and tap limits.
  localparam int HistDepth       = 3;
  localparam int MaxTaps         = HistDepth + 1;
  localparam int DefForwardTaps  = 4;
  localparam int DefFeedbackTaps = 4;

  // Coefficient register file.
  localparam int NumRegs = 2 * HistDepth + 1;
  localparam int CfgIdxW = 3;

  // Register indexes.
  localparam int RegFwd0 = 0;   // b[0]..b[3] at 0..3
  localparam int RegFb1  = 4;   // a[1]..a[3] at 4..6

  localparam logic signed [CoeffW-1:0] CoeffOne = 32'sh4000_0000;  // 1.0 in Q2.30

  typedef logic signed [DataW-1:0]  sample_t;
  typedef logic signed [CoeffW-1:0] coeff_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [AccW-1:0]   acc_t;

  typedef struct packed {
    sample_t data;
    logic    sat;
  } result_t;

endpackage

`default_nettype wire

/* rtl/iirdf1_tap_cell.sv */
// One tap of the filter chain: holds x[n-k] and y[n-k] and forms its term.
// Depends on iirdf1_pkg.
`default_nettype none

module iirdf1_tap_cell #(
  parameter bit UseFwd = 1'b1,
  parameter bit UseFb  = 1'b1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   shift_i,
  input  iirdf1_pkg::sample_t   x_i,
  input  iirdf1_pkg::sample_t   y_i,
  input  iirdf1_pkg::coeff_t    b_coeff_i,
  input  iirdf1_pkg::coeff_t    a_coeff_i,
  output iirdf1_pkg::sample_t   x_o,
  output iirdf1_pkg::sample_t   y_o,
  output iirdf1_pkg::term_t     term_o
);
  import iirdf1_pkg::*;

  sample_t x_q, y_q;
  logic signed [ProdW-1:0] fwd_prod, fb_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (shift_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  // signed products; disabled taps contribute zero
  always_comb begin
    fwd_prod = '0;
    fb_prod  = '0;
    if (UseFwd) begin
      fwd_prod = x_q * b_coeff_i;
    end
    if (UseFb) begin
      fb_prod = y_q * a_coeff_i;
    end
    term_o   = TermW'(fwd_prod) - TermW'(fb_prod);
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

`default_nettype wire

/* rtl/iirdf1_round_sat.sv */
// Round-half-up of the Q x.46 sum into Q16.16, then saturate to 32 bits.
// Depends on iirdf1_pkg.
`default_nettype none

module iirdf1_round_sat (
  input  iirdf1_pkg::acc_t    acc_i,
  output iirdf1_pkg::result_t res_o
);
  import iirdf1_pkg::*;

  localparam acc_t RoundHalf = {{(AccW - FracShift + 1){1'b0}}, {(FracShift - 1){1'b0}}}
                               | (acc_t'(1) <<< (FracShift - 1));

  acc_t                      rounded;
  logic signed [RoundW-1:0]  scaled;
  logic                      fits;

  always_comb begin
    rounded = acc_i + RoundHalf;
    scaled  = rounded[AccW-1:FracShift];
    // fits when all bits above the output sign agree with it
    fits    = (scaled[RoundW-1:DataW-1] == '0) || (scaled[RoundW-1:DataW-1] == '1);
    res_o.sat = !fits;
    if (fits) begin
      res_o.data = scaled[DataW-1:0];
    end else if (scaled[RoundW-1]) begin
      res_o.data = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res_o.data = {1'b0, {(DataW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

/* rtl/iir_direct_form_one_filter_top.sv */
// Direct form I IIR filter, top level. Instantiates the tap cells and the
// round/saturate stage; depends on iirdf1_pkg.
`default_nettype none

// One Q16.16 sample word in, one Q16.16 output word plus a saturation flag out.
// Accepts a word every clock cycle while in_ready_o is high; the result appears
// in the output register in the cycle after the input is taken. The throughput
// is set by the feedback path: y[n] goes through one tap cell's multiplier, the
// four-term adder and the round/saturate stage before it is shifted into the
// history for the next word. The output register decouples the two channels:
// a new word is taken whenever the output register is empty or is being drained
// that cycle. Coefficients are signed Q2.30 registers 0..6 (b0..b3, a1..a3,
// a0 = 1 is implicit); b0 resets to 1.0, the rest to 0. Writes to index 7 are
// dropped. Coefficient writes are expected only while the filter is idle.
// FORWARD_TAPS / FEEDBACK_TAPS (1..4) disable the higher taps; the history
// always shifts all three entries.
module iir_direct_form_one_filter_top #(
  parameter int FORWARD_TAPS  = iirdf1_pkg::DefForwardTaps,
  parameter int FEEDBACK_TAPS = iirdf1_pkg::DefFeedbackTaps
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // sample input channel
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  iirdf1_pkg::sample_t            sample_in_i,
  // result channel
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output iirdf1_pkg::sample_t            filtered_out_o,
  output logic                           saturated_o,
  // coefficient write channel
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [iirdf1_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  iirdf1_pkg::coeff_t             cfg_data_i
);
  import iirdf1_pkg::*;

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  coeff_t coeff_q [NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        coeff_q[i] <= (i == RegFwd0) ? CoeffOne : '0;
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < NumRegs; i++) begin
        if (cfg_index_i == CfgIdxW'(i)) begin
          coeff_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: output register with pass-through ready
  // ---------------------------------------------------------------------------
  logic    accept;
  logic    out_valid_q;
  result_t out_res_q;
  result_t new_res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Tap chain: cell k holds x[n-k], y[n-k]; history shifts one cell per word
  // ---------------------------------------------------------------------------
  sample_t x_chain [HistDepth];
  sample_t y_chain [HistDepth];
  term_t   terms   [HistDepth];

  assign x_chain[0] = sample_in_i;
  assign y_chain[0] = new_res.data;   // saturated value enters the history

  for (genvar k = 1; k <= HistDepth; k++) begin : g_tap
    if (k < HistDepth) begin : g_mid
      iirdf1_tap_cell #(
        .UseFwd (FORWARD_TAPS > k),
        .UseFb  (FEEDBACK_TAPS > k)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (accept),
        .x_i       (x_chain[k-1]),
        .y_i       (y_chain[k-1]),
        .b_coeff_i (coeff_q[RegFwd0 + k]),
        .a_coeff_i (coeff_q[RegFb1 + k - 1]),
        .x_o       (x_chain[k]),
        .y_o       (y_chain[k]),
        .term_o    (terms[k-1])
      );
    end else begin : g_last
      iirdf1_tap_cell #(
        .UseFwd (FORWARD_TAPS > k),
        .UseFb  (FEEDBACK_TAPS > k)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (accept),
        .x_i       (x_chain[k-1]),
        .y_i       (y_chain[k-1]),
        .b_coeff_i (coeff_q[RegFwd0 + k]),
        .a_coeff_i (coeff_q[RegFb1 + k - 1]),
        .x_o       (),
        .y_o       (),
        .term_o    (terms[k-1])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Current-sample product and sum of all taps (exact, 67 bits)
  // ---------------------------------------------------------------------------
  logic signed [ProdW-1:0] cur_prod;
  acc_t                    acc_sum;

  always_comb begin
    cur_prod = sample_in_i * coeff_q[RegFwd0];
    acc_sum  = AccW'(cur_prod);
    for (int k = 0; k < HistDepth; k++) begin
      acc_sum = acc_sum + AccW'(terms[k]);
    end
  end

  iirdf1_round_sat u_round_sat (
    .acc_i (acc_sum),
    .res_o (new_res)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_res_q <= new_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = out_res_q.data;
  assign saturated_o    = out_res_q.sat;

endmodule

`default_nettype wire
